### rtl/swm_pkg.sv
package swm_pkg;

    localparam int WINDOW_MAX   = 16;
    localparam int SAMPLE_WIDTH = 16;
    localparam int CFG_W        = 5;
    localparam int CNT_W        = $clog2(WINDOW_MAX + 1);
    localparam int IDX_W        = $clog2(WINDOW_MAX);
    localparam int CFG_RESET    = 4;

    typedef logic signed [SAMPLE_WIDTH-1:0] t_sample;

    // per-item command broadcast to every cell
    typedef struct packed {
        logic    en;
        logic    clr;
        logic    rm;
        logic    flush;
        t_sample key;
        t_sample old;
    } t_op;

    // left to right: compacted entry, its valid, its <= flag, removal seen so far
    typedef struct packed {
        t_sample c;
        logic    vc;
        logic    le;
        logic    seen;
    } t_link;

    // right to left: stored entry and its valid
    typedef struct packed {
        t_sample k;
        logic    vld;
    } t_tap;

    // zero acts as one, anything above the row length acts as the row length
    function automatic logic [CNT_W-1:0] eff_size(input logic [CFG_W-1:0] ws);
        logic [CNT_W-1:0] r;
        if (ws == '0) begin
            r = CNT_W'(1);
        end else if (int'(ws) > WINDOW_MAX) begin
            r = CNT_W'(WINDOW_MAX);
        end else begin
            r = CNT_W'(ws);
        end
        return r;
    endfunction

endpackage

### rtl/swm_if.sv
interface swm_in_if;
    logic                   valid;
    logic                   ready;
    swm_pkg::t_sample       sample;
    logic                   start_req;

    modport source (output valid, output sample, output start_req, input ready);
    modport sink   (input valid, input sample, input start_req, output ready);
endinterface

interface swm_out_if;
    logic                   valid;
    logic                   ready;
    swm_pkg::t_sample       window_min;

    modport source (output valid, output window_min, input ready);
    modport sink   (input valid, input window_min, output ready);
endinterface

### rtl/swm_cell.sv
module swm_cell (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  swm_pkg::t_op     i_op,
    input  swm_pkg::t_link   i_left,
    input  swm_pkg::t_tap    i_right,
    output swm_pkg::t_link   o_right,
    output swm_pkg::t_tap    o_left
);

    logic             r_vld;
    logic             n_vld;
    swm_pkg::t_sample r_k;
    swm_pkg::t_sample n_k;
    logic             vld_e;
    logic             eq;
    logic             shift;
    swm_pkg::t_sample c;
    logic             vc;
    logic             le;

    always_comb begin
        vld_e = r_vld & ~i_op.clr;
        // first matching entry and everything after it close up from the right
        eq    = vld_e && (r_k == i_op.old);
        shift = i_op.rm && (i_left.seen || eq);
        c     = shift ? i_right.k : r_k;
        vc    = shift ? i_right.vld : vld_e;
        le    = vc && ($signed(c) <= $signed(i_op.key));
        // keep, take the new key, or take the left neighbour's entry
        if (le) begin
            n_k = c;
        end else if (i_left.le) begin
            n_k = i_op.key;
        end else begin
            n_k = i_left.c;
        end
        n_vld = vc || i_left.vc;
    end

    assign o_right.c    = c;
    assign o_right.vc   = vc;
    assign o_right.le   = le;
    assign o_right.seen = i_left.seen || eq;
    assign o_left.k     = r_k;
    assign o_left.vld   = vld_e;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_op.flush) begin
            r_vld <= 1'b0;
        end else if (i_op.en) begin
            r_vld <= n_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_op.en) begin
            r_k <= n_k;
        end
    end

endmodule

### rtl/swm_delay.sv
module swm_delay (
    input  logic                       i_clk,
    input  logic                       i_en,
    input  swm_pkg::t_sample           i_key,
    input  logic [swm_pkg::IDX_W-1:0]  i_sel,
    output swm_pkg::t_sample           o_old
);

    swm_pkg::t_sample r_tap [swm_pkg::WINDOW_MAX];

    // newest at tap 0, the sample window_size items back at tap window_size-1
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_tap[0] <= i_key;
            for (int i = 1; i < swm_pkg::WINDOW_MAX; i++) begin
                r_tap[i] <= r_tap[i-1];
            end
        end
    end

    assign o_old = r_tap[i_sel];

endmodule

### rtl/sliding_window_minimum.sv
// Running minimum over the last window_size signed samples (1 to 16, reset 4; zero acts as 1).
// The window is a row of cells kept in ascending order; on each item the cells drop the oldest
// sample (taken from a delay line) once the window is full and insert the new one in the same update,
// so one item is accepted every clock while the output register is empty or being drained; the
// result is registered and appears in the cycle after its item. No result is given until the
// window has filled; start_req empties the window before its own sample enters, and any write
// to window_size empties it as well.
module sliding_window_minimum (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [swm_pkg::CFG_W-1:0]    i_cfg_wdata,
    swm_in_if.sink                       i_in,
    swm_out_if.source                    o_out
);

    logic [swm_pkg::CFG_W-1:0] r_window_size;
    logic [swm_pkg::CNT_W-1:0] r_fill;
    logic [swm_pkg::CNT_W-1:0] n_fill;
    logic [swm_pkg::CNT_W-1:0] w_eff;
    logic [swm_pkg::CNT_W-1:0] w_m1;
    logic                      r_ovld;
    swm_pkg::t_sample          r_min;
    swm_pkg::t_sample          w_min;
    swm_pkg::t_sample          w_old;
    logic                      acc;
    logic                      full;
    logic                      emit;
    swm_pkg::t_op              w_op;
    swm_pkg::t_link            w_link [swm_pkg::WINDOW_MAX+1];
    swm_pkg::t_tap             w_tap  [swm_pkg::WINDOW_MAX+1];

    assign i_in.ready = !r_ovld || o_out.ready;
    assign acc        = i_in.valid && i_in.ready;

    assign w_eff = swm_pkg::eff_size(r_window_size);
    assign w_m1  = w_eff - swm_pkg::CNT_W'(1);
    assign full  = !i_in.start_req && (r_fill == w_eff);

    always_comb begin
        if (i_in.start_req) begin
            n_fill = swm_pkg::CNT_W'(1);
        end else if (full) begin
            n_fill = r_fill;
        end else begin
            n_fill = r_fill + swm_pkg::CNT_W'(1);
        end
    end

    assign emit = (n_fill == w_eff);

    swm_delay u_delay (
        .i_clk (i_clk),
        .i_en  (acc),
        .i_key (i_in.sample),
        .i_sel (w_m1[swm_pkg::IDX_W-1:0]),
        .o_old (w_old)
    );

    assign w_op.en    = acc;
    assign w_op.clr   = i_in.start_req;
    assign w_op.rm    = full;
    assign w_op.flush = i_cfg_we;
    assign w_op.key   = i_in.sample;
    assign w_op.old   = w_old;

    // left end: everything to the left counts as smaller, nothing removed yet
    assign w_link[0].c    = '0;
    assign w_link[0].vc   = 1'b1;
    assign w_link[0].le   = 1'b1;
    assign w_link[0].seen = 1'b0;
    assign w_tap[swm_pkg::WINDOW_MAX] = '0;

    for (genvar g = 0; g < swm_pkg::WINDOW_MAX; g++) begin : g_cell
        swm_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_op    (w_op),
            .i_left  (w_link[g]),
            .i_right (w_tap[g+1]),
            .o_right (w_link[g+1]),
            .o_left  (w_tap[g])
        );
    end

    // head cell's next value
    assign w_min = w_link[1].le ? w_link[1].c : i_in.sample;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_size <= swm_pkg::CFG_W'(swm_pkg::CFG_RESET);
            r_fill        <= '0;
            r_ovld        <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_window_size <= i_cfg_wdata;
                r_fill        <= '0;
            end else if (acc) begin
                r_fill <= n_fill;
            end
            if (acc && emit) begin
                r_ovld <= 1'b1;
            end else if (o_out.ready) begin
                r_ovld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc && emit) begin
            r_min <= w_min;
        end
    end

    assign o_out.valid      = r_ovld;
    assign o_out.window_min = r_min;

`ifndef SYNTHESIS
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= w_eff)
        else $error("fill count beyond window size");

    a_old_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && full) |-> w_link[swm_pkg::WINDOW_MAX].seen)
        else $error("oldest sample not found in sorted row");

    a_head_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fill != '0 && !i_in.start_req) |-> w_tap[0].vld)
        else $error("head cell empty while window holds samples");

    a_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && emit) |=> (o_out.valid && o_out.window_min == $past(w_min)))
        else $error("result not presented after full window");
`endif

endmodule
